@@ design/ddo_pkg.sv @@
// ---------------------------------------------------------------------------
// Differential drive odometry package
// Shared widths, register reset values, fixed-point constants, the CORDIC
// arctangent table and a 32-bit saturation helper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ddo_pkg;

   // Field widths.
   localparam int CountW   = 32;
   localparam int UsW      = 24;
   localparam int DpcW     = 32;
   localparam int IwbW     = 24;
   localparam int CsrIndexW = 4;
   localparam int CsrDataW = 32;

   // Shared multiplier operand and product widths.
   localparam int MulW  = 33;
   localparam int ProdW = 2 * MulW;

   // CORDIC vector and angle width, with guard bits for growth.
   localparam int CrdW = 34;

   // Register reset values.
   localparam logic [DpcW-1:0] DistPerCountReset = 32'd609000;
   localparam logic [IwbW-1:0] InvWheelBaseReset = 24'd327680;

   // Register indexes.
   localparam logic [CsrIndexW-1:0] CsrDistPerCount = 4'd0;
   localparam logic [CsrIndexW-1:0] CsrInvWheelBase = 4'd1;

   // Fixed-point constants.
   localparam logic [63:0] RadToBam = 64'h28BE_60DB_9391_054A;
   localparam logic [31:0] InvGain  = 32'h9B74_EDA8;
   localparam logic [19:0] UsPerS   = 20'd1000000;

   // Quotient bits produced by the divider after the overflow check.
   localparam int QuotBits = 31;

   // CORDIC iteration count and arctangent table in binary angle units.
   localparam int CordicIterations = 24;
   localparam int AtanDepth = 32;
   localparam int AtanIdxW  = $clog2(AtanDepth);

   localparam logic [31:0] AtanBam [AtanDepth] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   // Clamp a signed 64-bit value to the signed 32-bit range.
   function automatic logic signed [31:0] saturate32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v[63:31] == {33{v[63]}}) begin
         r = v[31:0];
      end else if (v[63]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ design/ddo_mul.sv @@
// ---------------------------------------------------------------------------
// Shared multiplier
// Signed 33 x 33 multiply with a registered product; one product per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ddo_mul (
   input  wire logic                                clock,
   input  wire logic signed [ddo_pkg::MulW-1:0]     mul_a,
   input  wire logic signed [ddo_pkg::MulW-1:0]     mul_b,
   output logic signed      [ddo_pkg::ProdW-1:0]    mul_p
);

   logic signed [ddo_pkg::ProdW-1:0] prod_ff;

   // The product is registered and appears in the cycle after the operands.
   always_ff @(posedge clock) begin
      prod_ff <= ddo_pkg::ProdW'(mul_a) * ddo_pkg::ProdW'(mul_b);
   end

   assign mul_p = prod_ff;

endmodule

`default_nettype wire

@@ design/ddo_div.sv @@
// ---------------------------------------------------------------------------
// Serial divider
// Signed 64-bit numerator over an unsigned 24-bit divisor, truncated toward
// zero and saturated to 32 bits; one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ddo_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             div_start,
   input  wire logic signed [63:0]               div_num,
   input  wire logic        [ddo_pkg::UsW-1:0]   div_den,
   output logic                                  div_done,
   output logic signed      [31:0]               div_quot
);

   logic                          busy_ff;
   logic                          done_ff;
   logic [4:0]                    cnt_ff;
   logic [ddo_pkg::UsW-1:0]       rem_ff;
   logic [ddo_pkg::QuotBits-1:0]  sh_ff;
   logic                          neg_ff;
   logic signed [31:0]            quot_ff;

   logic [63:0]                   mag;
   logic                          ovf;
   logic [ddo_pkg::UsW:0]         trial;
   logic                          qbit;
   logic [ddo_pkg::UsW-1:0]       rem_in;
   logic [ddo_pkg::QuotBits-1:0]  quot_in;

   // Magnitude and overflow check: a quotient of 2^31 or more saturates.
   always_comb begin
      mag = div_num[63] ? 64'(-div_num) : div_num;
      ovf = (mag[63:31] >= {9'b0, div_den});
   end

   // One restoring step.
   always_comb begin
      trial   = {rem_ff, sh_ff[ddo_pkg::QuotBits-1]} - {1'b0, div_den};
      qbit    = !trial[ddo_pkg::UsW];
      rem_in  = qbit ? trial[ddo_pkg::UsW-1:0]
                     : {rem_ff[ddo_pkg::UsW-2:0], sh_ff[ddo_pkg::QuotBits-1]};
      quot_in = {sh_ff[ddo_pkg::QuotBits-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_start) begin
            neg_ff <= div_num[63];
            if (ovf) begin
               quot_ff <= div_num[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
               cnt_ff  <= '0;
               rem_ff  <= mag[54:31];
               sh_ff   <= mag[30:0];
            end
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            sh_ff  <= quot_in;
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(ddo_pkg::QuotBits - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               quot_ff <= neg_ff ? 32'(-{1'b0, quot_in}) : {1'b0, quot_in};
            end
         end
      end
   end

   assign div_done = done_ff;
   assign div_quot = quot_ff;

endmodule

`default_nettype wire

@@ design/ddo_cordic.sv @@
// ---------------------------------------------------------------------------
// CORDIC rotator
// Rotation mode with binary-angle arctangents; one iteration per cycle
// through shifters and add/subtract units reused by every iteration.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ddo_cordic #(
   parameter int ITERATIONS = ddo_pkg::CordicIterations
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                crd_start,
   input  wire logic signed [ddo_pkg::CrdW-1:0]     crd_x0,
   input  wire logic signed [ddo_pkg::CrdW-1:0]     crd_z0,
   output logic                                     crd_done,
   output logic signed      [ddo_pkg::CrdW-1:0]     crd_x,
   output logic signed      [ddo_pkg::CrdW-1:0]     crd_y
);

   logic                                busy_ff;
   logic                                done_ff;
   logic [ddo_pkg::AtanIdxW-1:0]        cnt_ff;
   logic signed [ddo_pkg::CrdW-1:0]     x_ff;
   logic signed [ddo_pkg::CrdW-1:0]     y_ff;
   logic signed [ddo_pkg::CrdW-1:0]     z_ff;

   logic signed [ddo_pkg::CrdW-1:0]     xs;
   logic signed [ddo_pkg::CrdW-1:0]     ys;
   logic signed [ddo_pkg::CrdW-1:0]     atan;
   logic signed [ddo_pkg::CrdW-1:0]     x_in;
   logic signed [ddo_pkg::CrdW-1:0]     y_in;
   logic signed [ddo_pkg::CrdW-1:0]     z_in;

   // One micro-rotation; a zero residual turns counterclockwise.
   always_comb begin
      xs   = x_ff >>> cnt_ff;
      ys   = y_ff >>> cnt_ff;
      atan = signed'({2'b00, ddo_pkg::AtanBam[cnt_ff]});
      if (!z_ff[ddo_pkg::CrdW-1]) begin
         x_in = x_ff - ys;
         y_in = y_ff + xs;
         z_in = z_ff - atan;
      end else begin
         x_in = x_ff + ys;
         y_in = y_ff - xs;
         z_in = z_ff + atan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (crd_start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            x_ff    <= crd_x0;
            y_ff    <= '0;
            z_ff    <= crd_z0;
         end else if (busy_ff) begin
            x_ff   <= x_in;
            y_ff   <= y_in;
            z_ff   <= z_in;
            cnt_ff <= cnt_ff + ddo_pkg::AtanIdxW'(1);
            if (cnt_ff == ddo_pkg::AtanIdxW'(ITERATIONS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign crd_done = done_ff;
   assign crd_x    = x_ff;
   assign crd_y    = y_ff;

endmodule

`default_nettype wire

@@ design/differential_drive_odometry_top.sv @@
// ---------------------------------------------------------------------------
// Differential drive wheel odometry
// Turns absolute wheel encoder counts into an accumulated pose and the
// velocities over each interval, using one shared multiplier, a CORDIC
// rotator and a serial divider under a small sequencer.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Contents
//   req_     in         req_valid/req_ready  left count, right count, interval
//   rsp_     out        rsp_valid/rsp_ready  pose, velocities, zero flag
//   csr_     in         csr_valid/csr_ready  register index and write word
//
// One word passes through the setup and multiply steps, the rotation, the pose
// update and, for each velocity, two multiplies and a division; the serial
// divider takes most of the time.
// A zero interval skips the velocity work.
// req_ready is high only while the sequencer is idle. A finished result waits
// in the output register, and a new word is taken meanwhile; the sequencer
// holds at its last step only if the previous result is still not taken.
// Reset is synchronous and clears the pose, the previous counts and the
// registers to their reset values; csr_ready is always high.
//
`timescale 1ns / 1ps
`default_nettype none

module differential_drive_odometry_top #(
   parameter int CORDIC_ITERATIONS = ddo_pkg::CordicIterations
) (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [ddo_pkg::CountW-1:0]   req_left_count,
   input  wire logic signed [ddo_pkg::CountW-1:0]   req_right_count,
   input  wire logic        [ddo_pkg::UsW-1:0]      req_elapsed_us,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed      [31:0]                  rsp_pos_x,
   output logic signed      [31:0]                  rsp_pos_y,
   output logic             [31:0]                  rsp_heading,
   output logic signed      [31:0]                  rsp_vel_x,
   output logic signed      [31:0]                  rsp_vel_y,
   output logic signed      [31:0]                  rsp_vel_turn,
   output logic                                     rsp_zero_interval,

   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic        [ddo_pkg::CsrIndexW-1:0] csr_index,
   input  wire logic        [ddo_pkg::CsrDataW-1:0]  csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_DL, ST_DR, ST_SUM, ST_RAD, ST_GAIN, ST_B00, ST_B01, ST_B10,
      ST_B11, ST_FOLD, ST_ROT, ST_CRD, ST_POSE, ST_VLO, ST_VHI, ST_VSUM,
      ST_VDIV, ST_VWAIT, ST_DONE
   } state_type;

   localparam int W = ddo_pkg::MulW;

   state_type                          state_ff;

   // Configuration and odometry state.
   logic [ddo_pkg::DpcW-1:0]           dpc_ff;
   logic [ddo_pkg::IwbW-1:0]           iwb_ff;
   logic [31:0]                        left_prev_ff;
   logic [31:0]                        right_prev_ff;
   logic signed [31:0]                 pose_x_ff;
   logic signed [31:0]                 pose_y_ff;
   logic [31:0]                        heading_ff;

   // Working registers of one word.
   logic [31:0]                        lc_ff;
   logic [31:0]                        rc_ff;
   logic [ddo_pkg::UsW-1:0]            us_ff;
   logic signed [47:0]                 lm_ff;
   logic signed [31:0]                 dist_ff;
   logic signed [31:0]                 diff_ff;
   logic signed [55:0]                 rad_ff;
   logic signed [ddo_pkg::CrdW-1:0]    x0_ff;
   logic signed [127:0]                acc_ff;
   logic [1:0]                         vel_idx_ff;
   logic [39:0]                        nlo_ff;
   logic signed [63:0]                 num_ff;
   logic signed [31:0]                 vel_x_ff;
   logic signed [31:0]                 vel_y_ff;
   logic signed [31:0]                 vel_turn_ff;

   // Result register.
   logic                               rsp_valid_ff;
   logic signed [31:0]                 rsp_pos_x_ff;
   logic signed [31:0]                 rsp_pos_y_ff;
   logic [31:0]                        rsp_heading_ff;
   logic signed [31:0]                 rsp_vel_x_ff;
   logic signed [31:0]                 rsp_vel_y_ff;
   logic signed [31:0]                 rsp_vel_turn_ff;
   logic                               rsp_zero_ff;

   // Shared units.
   logic signed [W-1:0]                mul_a;
   logic signed [W-1:0]                mul_b;
   logic signed [ddo_pkg::ProdW-1:0]   mul_p;
   logic signed [127:0]                prod_ext;
   logic                               crd_start;
   logic signed [ddo_pkg::CrdW-1:0]    crd_x0;
   logic signed [ddo_pkg::CrdW-1:0]    crd_z0;
   logic                               crd_done;
   logic signed [ddo_pkg::CrdW-1:0]    crd_x;
   logic signed [ddo_pkg::CrdW-1:0]    crd_y;
   logic                               div_start;
   logic                               div_done;
   logic signed [31:0]                 div_quot;

   // Datapath intermediates.
   logic signed [31:0]                 dl;
   logic signed [31:0]                 dr;
   logic signed [47:0]                 rm;
   logic signed [48:0]                 sum49;
   logic signed [48:0]                 diff49;
   logic [31:0]                        mid;
   logic [31:0]                        mid_rot;
   logic                               quad;
   logic signed [39:0]                 vel_src;
   logic                               rsp_load;

   ddo_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   ddo_cordic #(
      .ITERATIONS (CORDIC_ITERATIONS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .crd_start (crd_start),
      .crd_x0    (crd_x0),
      .crd_z0    (crd_z0),
      .crd_done  (crd_done),
      .crd_x     (crd_x),
      .crd_y     (crd_y)
   );

   ddo_div u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .div_num   (num_ff),
      .div_den   (us_ff),
      .div_done  (div_done),
      .div_quot  (div_quot)
   );

   // Count deltas, wheel travel sum and difference.
   always_comb begin
      dl       = signed'(lc_ff - left_prev_ff);
      dr       = signed'(rc_ff - right_prev_ff);
      rm       = signed'(mul_p[63:16]);
      sum49    = 49'(lm_ff) + 49'(rm);
      diff49   = 49'(rm) - 49'(lm_ff);
      prod_ext = 128'(mul_p);
   end

   // Mid-step heading folded into the right half-plane.
   always_comb begin
      mid     = heading_ff + acc_ff[96:65];
      mid_rot = mid + 32'h4000_0000;
      quad    = mid_rot[31];
      crd_x0  = quad ? -x0_ff : x0_ff;
      crd_z0  = ddo_pkg::CrdW'(signed'(quad ? {~mid[31], mid[30:0]} : mid));
   end

   // Velocity numerator source.
   always_comb begin
      unique case (vel_idx_ff)
         2'd0:    vel_src = 40'(ddo_pkg::saturate32(64'(crd_x)));
         2'd1:    vel_src = 40'(ddo_pkg::saturate32(64'(crd_y)));
         2'd2:    vel_src = 40'(rad_ff >>> 16);
         default: vel_src = '0;
      endcase
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_DL: begin
            mul_a = W'(dl);
            mul_b = {1'b0, dpc_ff};
         end
         ST_DR: begin
            mul_a = W'(dr);
            mul_b = {1'b0, dpc_ff};
         end
         ST_RAD: begin
            mul_a = W'(diff_ff);
            mul_b = {9'b0, iwb_ff};
         end
         ST_GAIN: begin
            mul_a = W'(dist_ff);
            mul_b = {1'b0, ddo_pkg::InvGain};
         end
         ST_B00: begin
            mul_a = {1'b0, rad_ff[31:0]};
            mul_b = {1'b0, ddo_pkg::RadToBam[31:0]};
         end
         ST_B01: begin
            mul_a = {1'b0, rad_ff[31:0]};
            mul_b = {1'b0, ddo_pkg::RadToBam[63:32]};
         end
         ST_B10: begin
            mul_a = W'(signed'(rad_ff[55:32]));
            mul_b = {1'b0, ddo_pkg::RadToBam[31:0]};
         end
         ST_B11: begin
            mul_a = W'(signed'(rad_ff[55:32]));
            mul_b = {1'b0, ddo_pkg::RadToBam[63:32]};
         end
         ST_VLO: begin
            mul_a = {13'b0, vel_src[19:0]};
            mul_b = {13'b0, ddo_pkg::UsPerS};
         end
         ST_VHI: begin
            mul_a = W'(signed'(vel_src[39:20]));
            mul_b = {13'b0, ddo_pkg::UsPerS};
         end
         default: begin
         end
      endcase
   end

   assign crd_start = (state_ff == ST_ROT);
   assign div_start = (state_ff == ST_VDIV);
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Sequencer with state, working registers and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         dpc_ff        <= ddo_pkg::DistPerCountReset;
         iwb_ff        <= ddo_pkg::InvWheelBaseReset;
         left_prev_ff  <= '0;
         right_prev_ff <= '0;
         pose_x_ff     <= '0;
         pose_y_ff     <= '0;
         heading_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // Register writes.
         if (csr_valid) begin
            if (csr_index == ddo_pkg::CsrDistPerCount) begin
               dpc_ff <= csr_wdata;
            end else if (csr_index == ddo_pkg::CsrInvWheelBase) begin
               iwb_ff <= csr_wdata[ddo_pkg::IwbW-1:0];
            end
         end

         // Result handshake.
         if (rsp_load) begin
            rsp_valid_ff    <= 1'b1;
            rsp_pos_x_ff    <= pose_x_ff;
            rsp_pos_y_ff    <= pose_y_ff;
            rsp_heading_ff  <= heading_ff;
            rsp_vel_x_ff    <= vel_x_ff;
            rsp_vel_y_ff    <= vel_y_ff;
            rsp_vel_turn_ff <= vel_turn_ff;
            rsp_zero_ff     <= (us_ff == '0);
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  lc_ff    <= req_left_count;
                  rc_ff    <= req_right_count;
                  us_ff    <= req_elapsed_us;
                  state_ff <= ST_DL;
               end
            end
            ST_DL: state_ff <= ST_DR;
            ST_DR: begin
               lm_ff    <= signed'(mul_p[63:16]);
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               dist_ff  <= ddo_pkg::saturate32(64'(sum49 >>> 1));
               diff_ff  <= ddo_pkg::saturate32(64'(diff49));
               state_ff <= ST_RAD;
            end
            ST_RAD: state_ff <= ST_GAIN;
            ST_GAIN: begin
               rad_ff   <= signed'(mul_p[55:0]);
               state_ff <= ST_B00;
            end
            ST_B00: begin
               x0_ff    <= signed'(mul_p[65:32]);
               state_ff <= ST_B01;
            end
            ST_B01: begin
               acc_ff   <= prod_ext;
               state_ff <= ST_B10;
            end
            ST_B10: begin
               acc_ff   <= acc_ff + (prod_ext <<< 32);
               state_ff <= ST_B11;
            end
            ST_B11: begin
               acc_ff   <= acc_ff + (prod_ext <<< 32);
               state_ff <= ST_FOLD;
            end
            ST_FOLD: begin
               acc_ff   <= acc_ff + (prod_ext <<< 64);
               state_ff <= ST_ROT;
            end
            ST_ROT: state_ff <= ST_CRD;
            ST_CRD: begin
               if (crd_done) begin
                  state_ff <= ST_POSE;
               end
            end
            ST_POSE: begin
               pose_x_ff     <= ddo_pkg::saturate32(64'(pose_x_ff) + 64'(crd_x));
               pose_y_ff     <= ddo_pkg::saturate32(64'(pose_y_ff) + 64'(crd_y));
               heading_ff    <= heading_ff + acc_ff[95:64];
               left_prev_ff  <= lc_ff;
               right_prev_ff <= rc_ff;
               vel_idx_ff    <= 2'd0;
               if (us_ff == '0) begin
                  vel_x_ff    <= '0;
                  vel_y_ff    <= '0;
                  vel_turn_ff <= '0;
                  state_ff    <= ST_DONE;
               end else begin
                  state_ff <= ST_VLO;
               end
            end
            ST_VLO: state_ff <= ST_VHI;
            ST_VHI: begin
               nlo_ff   <= mul_p[39:0];
               state_ff <= ST_VSUM;
            end
            ST_VSUM: begin
               num_ff   <= 64'(prod_ext <<< 20) + signed'({24'b0, nlo_ff});
               state_ff <= ST_VDIV;
            end
            ST_VDIV: state_ff <= ST_VWAIT;
            ST_VWAIT: begin
               if (div_done) begin
                  if (vel_idx_ff == 2'd0) begin
                     vel_x_ff <= div_quot;
                  end else if (vel_idx_ff == 2'd1) begin
                     vel_y_ff <= div_quot;
                  end else begin
                     vel_turn_ff <= div_quot;
                  end
                  if (vel_idx_ff == 2'd2) begin
                     state_ff <= ST_DONE;
                  end else begin
                     vel_idx_ff <= vel_idx_ff + 2'd1;
                     state_ff   <= ST_VLO;
                  end
               end
            end
            ST_DONE: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pos_x         = rsp_pos_x_ff;
   assign rsp_pos_y         = rsp_pos_y_ff;
   assign rsp_heading       = rsp_heading_ff;
   assign rsp_vel_x         = rsp_vel_x_ff;
   assign rsp_vel_y         = rsp_vel_y_ff;
   assign rsp_vel_turn      = rsp_vel_turn_ff;
   assign rsp_zero_interval = rsp_zero_ff;

   // A zero interval word carries zero velocities.
   a_zero_vel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_interval) |->
         (rsp_vel_x == '0 && rsp_vel_y == '0 && rsp_vel_turn == '0))
      else $error("zero interval with nonzero velocity");

   // The divider never sees a zero divisor.
   a_div_den: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (us_ff != '0))
      else $error("divider started with zero interval");

   // After a word is taken the block is busy.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready right after accept");

   // The rotator finishes only while the sequencer waits for it.
   a_crd_done: assert property (@(posedge clock) disable iff (reset)
      crd_done |-> (state_ff == ST_CRD))
      else $error("rotation finished outside its wait step");

   // The divider finishes only while the sequencer waits for it.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_VWAIT))
      else $error("division finished outside its wait step");

endmodule

`default_nettype wire

@@ sim/differential_drive_odometry_top_tb.sv @@
// ---------------------------------------------------------------------------
// Differential drive odometry testbench
// Drives encoder words through the request channel and register writes
// through the CSR channel. A local predictor tracks pose, heading and
// registers, and every result word is compared field by field in order.
// The stimulus is a directed table followed by random phases that vary the
// registers and the idle patterns on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module differential_drive_odometry_top_tb;

   localparam int ResetCycles  = 12;
   localparam int SettleCycles = 200;
   localparam int QuietLimit   = 5000;
   localparam int LongHold     = 600;
   localparam int PhaseCount   = 8;
   localparam int PhaseWords   = 230;
   localparam logic [ddo_pkg::CsrIndexW-1:0] CsrUnusedIdx = 4'd9;
   localparam logic [31:0] IdxDpc    = 32'(ddo_pkg::CsrDistPerCount);
   localparam logic [31:0] IdxIwb    = 32'(ddo_pkg::CsrInvWheelBase);
   localparam logic [31:0] IdxUnused = 32'(CsrUnusedIdx);

   typedef struct {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] heading;
      logic [31:0] vel_x;
      logic [31:0] vel_y;
      logic [31:0] vel_turn;
      logic        zero_int;
   } odom_result_type;

   typedef enum logic {ROW_WORD, ROW_REG} row_kind_type;

   // For a register row, a is the index and b the write data.
   typedef struct {
      row_kind_type    kind;
      logic [31:0]     a;
      logic [31:0]     b;
      logic [23:0]     us;
      bit              typed;
      odom_result_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic signed [31:0]             req_left_count = '0;
   logic signed [31:0]             req_right_count = '0;
   logic [ddo_pkg::UsW-1:0]        req_elapsed_us = '0;

   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic signed [31:0]             rsp_pos_x;
   logic signed [31:0]             rsp_pos_y;
   logic [31:0]                    rsp_heading;
   logic signed [31:0]             rsp_vel_x;
   logic signed [31:0]             rsp_vel_y;
   logic signed [31:0]             rsp_vel_turn;
   logic                           rsp_zero_interval;

   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [ddo_pkg::CsrIndexW-1:0]  csr_index = '0;
   logic [ddo_pkg::CsrDataW-1:0]   csr_wdata = '0;

   // Predictor state and register copies.
   logic [31:0]   prev_left, prev_right, acc_heading;
   longint        acc_x, acc_y;
   logic [31:0]   reg_dpc;
   logic [23:0]   reg_iwb;

   odom_result_type  pose_q[$];

   int errors = 0;
   int words_sent = 0;
   int zero_words = 0;
   int reg_writes = 0;
   int results_seen = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_req = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int quiet = 0;

   // Directed table: reset state, zero registers, extreme counts and intervals.
   stim_row_type dir_table [24] = '{
      '{ROW_WORD, 32'h0, 32'h0, 24'h0, 1'b1, '{0, 0, 0, 0, 0, 0, 1}},
      '{ROW_WORD, 32'h0, 32'h0, 24'hFFFFFF, 1'b1, '{0, 0, 0, 0, 0, 0, 0}},
      '{ROW_REG, IdxDpc, 32'h0, 24'h0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
      '{ROW_WORD, 32'h7FFFFFFF, 32'h80000000, 24'h1, 1'b1, '{0, 0, 0, 0, 0, 0, 0}},
      '{ROW_REG, IdxDpc, 32'd609000, 24'h0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
      '{ROW_REG, IdxIwb, 32'h0, 24'h0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
      '{ROW_WORD, 32'h80000100, 32'h7FFFFE00, 24'd1000, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
      '{ROW_REG, IdxIwb, 32'd327680, 24'h0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
      '{ROW_WORD, 32'h80000200, 32'h80000000, 24'd20000, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
      '{ROW_WORD, 32'h80001200, 32'h80001200, 24'd20000, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
      '{ROW_WORD, 32'h0, 32'h0, 24'h0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
      '{ROW_WORD, 32'hFFFFC000, 32'h00004000, 24'h1, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
      '{ROW_REG, IdxDpc, 32'hFFFFFFFF, 24'h0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
      '{ROW_REG, IdxIwb, 32'h00FFFFFF, 24'h0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
      '{ROW_WORD, 32'h80000000, 32'h7FFFFFFF, 24'hFFFFFF, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
      '{ROW_WORD, 32'h7FFFFFFF, 32'h80000000, 24'h1, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
      '{ROW_WORD, 32'h7FFFFFFF, 32'h80000000, 24'h0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
      '{ROW_REG, IdxUnused, 32'hFFFFFFFF, 24'h0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
      '{ROW_REG, IdxDpc, 32'h1, 24'h0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
      '{ROW_REG, IdxIwb, 32'h1, 24'h0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
      '{ROW_WORD, 32'h12345678, 32'h87654321, 24'h1, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
      '{ROW_REG, IdxDpc, 32'd609000, 24'h0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
      '{ROW_REG, IdxIwb, 32'd327680, 24'h0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
      '{ROW_WORD, 32'h0, 32'h0, 24'd500, 1'b0, '{0, 0, 0, 0, 0, 0, 0}}
   };

   differential_drive_odometry_top DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Clamp to the signed 32-bit range.
   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic [31:0] rate_of(input longint v, input logic [23:0] us);
      return 32'(clamp32((v * longint'(ddo_pkg::UsPerS)) / longint'(us)));
   endfunction

   // Advance the pose by one encoder word and return the expected result.
   function automatic odom_result_type advance_pose(input logic [31:0] lc,
                                                    input logic [31:0] rc,
                                                    input logic [23:0] us);
      longint dl, dr, lm, rm, travel, diff, rad32, full, x, y, z, xs, ys;
      logic signed [127:0] wide;
      logic [31:0] step, half, mid, probe;
      odom_result_type r;
      dl = longint'($signed(lc - prev_left));
      dr = longint'($signed(rc - prev_right));
      lm = (dl * longint'(reg_dpc)) >>> 16;
      rm = (dr * longint'(reg_dpc)) >>> 16;
      travel = clamp32((lm + rm) >>> 1);
      diff = clamp32(rm - lm);
      rad32 = diff * longint'(reg_iwb);
      // Radians Q.32 to binary angle, floor of the product over 2^64.
      wide = rad32;
      wide = wide * $signed({64'd0, ddo_pkg::RadToBam});
      full = longint'(wide >>> 64);
      step = 32'(full);
      half = 32'(full >>> 1);
      mid = acc_heading + half;
      x = (travel * longint'(ddo_pkg::InvGain)) >>> 32;
      y = 0;
      // Fold the left half-plane onto the right one.
      probe = mid + 32'h4000_0000;
      if (probe[31]) begin
         x = -x;
         mid = mid - 32'h8000_0000;
      end
      z = longint'($signed(mid));
      for (int i = 0; i < ddo_pkg::CordicIterations; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - longint'(ddo_pkg::AtanBam[i]);
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + longint'(ddo_pkg::AtanBam[i]);
         end
      end
      acc_x = clamp32(acc_x + x);
      acc_y = clamp32(acc_y + y);
      acc_heading = acc_heading + step;
      prev_left = lc;
      prev_right = rc;
      r.pos_x = 32'(acc_x);
      r.pos_y = 32'(acc_y);
      r.heading = acc_heading;
      if (us == 0) begin
         r.vel_x = '0;
         r.vel_y = '0;
         r.vel_turn = '0;
         r.zero_int = 1'b1;
      end else begin
         r.vel_x = rate_of(clamp32(x), us);
         r.vel_y = rate_of(clamp32(y), us);
         r.vel_turn = rate_of(rad32 >>> 16, us);
         r.zero_int = 1'b0;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR result %0d %s: got %h, want %h", results_seen, what, got, want);
      errors++;
   endtask

   // Offer one encoder word, with an optional idle gap before it.
   task automatic send_word(input logic [31:0] lc, input logic [31:0] rc,
                            input logic [23:0] us, input bit typed,
                            input odom_result_type want);
      odom_result_type r;
      int gap;
      gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_left_count <= lc;
      req_right_count <= rc;
      req_elapsed_us <= us;
      do @(posedge clock); while (!req_ready);
      r = advance_pose(lc, rc, us);
      pose_q.push_back(typed ? want : r);
      words_sent++;
      if (us == 0) zero_words++;
   endtask

   // Stop offering and wait until every expected word has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pose_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ddo_pkg::CsrIndexW-1:0] idx,
                            input logic [31:0] data);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == ddo_pkg::CsrDistPerCount) reg_dpc = data;
      else if (idx == ddo_pkg::CsrInvWheelBase) reg_iwb = data[23:0];
      reg_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Receiver: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= LongHold;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Compare each result word against the oldest expectation.
   always @(posedge clock) begin
      odom_result_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pose_q.size() == 0) begin
            report_mismatch("unexpected word, pos_x", rsp_pos_x, '0);
         end else begin
            w = pose_q.pop_front();
            if (rsp_pos_x !== w.pos_x) report_mismatch("pos_x", rsp_pos_x, w.pos_x);
            if (rsp_pos_y !== w.pos_y) report_mismatch("pos_y", rsp_pos_y, w.pos_y);
            if (rsp_heading !== w.heading) report_mismatch("heading", rsp_heading, w.heading);
            if (rsp_vel_x !== w.vel_x) report_mismatch("vel_x", rsp_vel_x, w.vel_x);
            if (rsp_vel_y !== w.vel_y) report_mismatch("vel_y", rsp_vel_y, w.vel_y);
            if (rsp_vel_turn !== w.vel_turn)
               report_mismatch("vel_turn", rsp_vel_turn, w.vel_turn);
            if (rsp_zero_interval !== w.zero_int)
               report_mismatch("zero_interval", 32'(rsp_zero_interval), 32'(w.zero_int));
         end
      end
   end

   // Watchdog on cycles without any accepted word.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
      end
      if (quiet >= QuietLimit) begin
         $display("Timeout: no word accepted in %0d cycles", QuietLimit);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      logic [31:0] lc, rc, dpc;
      logic [23:0] us, iwb;
      odom_result_type none;
      int pick;
      none = '{0, 0, 0, 0, 0, 0, 0};
      prev_left = '0;
      prev_right = '0;
      acc_x = 0;
      acc_y = 0;
      acc_heading = '0;
      reg_dpc = ddo_pkg::DistPerCountReset;
      reg_iwb = ddo_pkg::InvWheelBaseReset;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table.
      foreach (dir_table[k]) begin
         if (dir_table[k].kind == ROW_REG) begin
            write_reg(dir_table[k].a[ddo_pkg::CsrIndexW-1:0], dir_table[k].b);
         end else begin
            send_word(dir_table[k].a, dir_table[k].b, dir_table[k].us,
                      dir_table[k].typed, dir_table[k].want);
         end
      end

      // Random phases: register settings and idle patterns vary per phase.
      lc = prev_left;
      rc = prev_right;
      for (int ph = 0; ph < PhaseCount; ph++) begin
         unique case (ph)
            0: begin
               dpc = ddo_pkg::DistPerCountReset;
               iwb = ddo_pkg::InvWheelBaseReset;
            end
            1: begin dpc = 32'h1; iwb = 24'h1; end
            2: begin dpc = 32'd609000; iwb = 24'hFFFFFF; end
            4: begin dpc = 32'hFFFFFFFF; iwb = 24'hFFFFFF; end
            5: begin dpc = 32'd2000000; iwb = 24'h1; end
            6: begin dpc = 32'h0; iwb = ddo_pkg::InvWheelBaseReset; end
            default: begin dpc = $urandom; iwb = 24'($urandom_range(1, 24'hFFFFFF)); end
         endcase
         write_reg(ddo_pkg::CsrDistPerCount, dpc);
         write_reg(ddo_pkg::CsrInvWheelBase, 32'(iwb));
         idle_pct  = (ph % 4 == 1) ? 58 : (ph % 4 == 3) ? 33 : 0;
         stall_pct = (ph % 4 == 2) ? 58 : (ph % 4 == 3) ? 33 : 0;
         for (int n = 0; n < PhaseWords; n++) begin
            if (ph == 2 && n == 60) hold_req <= hold_req + 1;
            if (ph == 5 && n == 100) drain_results();
            // Mostly small moves; some equal or opposite, some arbitrary.
            pick = $urandom_range(99);
            if (pick < 65) begin
               lc = lc + 32'($urandom_range(4000)) - 32'd2000;
               rc = rc + 32'($urandom_range(4000)) - 32'd2000;
            end else if (pick < 80) begin
               rc = 32'($urandom_range(6000)) - 32'd3000;
               lc = lc + ((pick < 72) ? rc : -rc);
               rc = prev_right + rc;
            end else begin
               lc = $urandom;
               rc = $urandom;
            end
            pick = $urandom_range(99);
            if (pick < 8) us = '0;
            else if (pick < 12) us = 24'hFFFFFF;
            else if (pick < 22) us = 24'($urandom);
            else us = 24'($urandom_range(1, 20000));
            send_word(lc, rc, us, 1'b0, none);
         end
      end

      drain_results();
      $display("Run covered %0d encoder words (%0d with zero interval) over %0d phases,",
               words_sent, zero_words, PhaseCount);
      $display("%0d register writes and %0d result words checked.", reg_writes, results_seen);
      if (errors == 0 && pose_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
